// ----- hdl/clt_pkg.sv -----
// Shared types, character codes and keyword table for the token lexer.
package clt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PREFIX_BYTES = 6;
   localparam int KW_COUNT = 7;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_WORD    = 3'd3,
      MODE_NUMBER  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_KEYWORD = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_NUMBER  = 3'd2,
      KIND_OPER    = 3'd3,
      KIND_COMMENT = 3'd4,
      KIND_PUNCT   = 3'd5,
      KIND_END     = 3'd6,
      KIND_ERROR   = 3'd7
   } kind_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  run_length;
      logic [47:0] prefix;
      logic        overflowed;
   } lex_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] length;
      logic [7:0] symbol;
      logic [2:0] kw_index;
      logic       truncated;
      logic       last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } step_out_type;

   typedef struct packed {
      logic       found;
      logic [2:0] index;
   } kw_hit_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h3D || c == 8'h3C || c == 8'h3E;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c == 8'h3B || c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D;
   endfunction

   // Keyword text, first character in the low byte, zero padded.
   function automatic logic [47:0] kw_text(input logic [2:0] idx);
      logic [47:0] t;
      case (idx)
         3'd0:    t = 48'h0000_0000_6669;
         3'd1:    t = 48'h0000_6573_6C65;
         3'd2:    t = 48'h0065_6C69_6877;
         3'd3:    t = 48'h6E72_7574_6572;
         3'd4:    t = 48'h0000_0074_6E69;
         3'd5:    t = 48'h0074_616F_6C66;
         3'd6:    t = 48'h0000_7261_6863;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] kw_len(input logic [2:0] idx);
      logic [7:0] n;
      case (idx)
         3'd0:    n = 8'd2;
         3'd1:    n = 8'd4;
         3'd2:    n = 8'd5;
         3'd3:    n = 8'd6;
         3'd4:    n = 8'd3;
         3'd5:    n = 8'd5;
         3'd6:    n = 8'd4;
         default: n = 8'd0;
      endcase
      return n;
   endfunction

   // Bytes beyond the kept length are zero, so a full-width compare plus a
   // length check matches exactly the keyword text.
   function automatic kw_hit_type kw_lookup(input logic [47:0] prefix,
                                            input logic [7:0] len);
      kw_hit_type hit;
      hit = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (prefix == kw_text(3'(k)) && len == kw_len(3'(k))) begin
            hit.found = 1'b1;
            hit.index = 3'(k);
         end
      end
      return hit;
   endfunction

endpackage

// ----- hdl/c_like_token_lexer.sv -----
// Top level of the byte-serial lexer for a small C-like language.
// The lexer takes one byte (or an end-of-input mark in req_tuser) per clock
// while req_tready is high and reports tokens one per clock on the rsp channel
// while rsp_tready is high. A byte can both end a word, number or lone slash and
// start a new token, so it can give two reports. Reports go through a four-entry
// queue, and req_tready is high while the queue has room for two, so bytes that
// give at most one report stream at one per cycle, while the output side moves
// one report per cycle. Words and numbers report their length up to
// min(TOKEN_MAX-1, 255) characters and flag the rest as truncated.
module c_like_token_lexer #(
   parameter int TOKEN_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] at_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] token_length, [15:8] symbol,
                                    // [18:16] keyword_index, [19] truncated
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int LEN_CAP = (TOKEN_MAX - 1 < 255) ? TOKEN_MAX - 1 : 255;

   clt_pkg::lex_state_type lex_ff, lex_in;
   clt_pkg::step_out_type step_res;
   clt_pkg::token_type head;
   logic accept;
   logic room_two;

   assign accept = req_tvalid && req_tready;
   assign req_tready = room_two;

   clt_step #(
      .LEN_CAP(LEN_CAP)
   ) u_step (
      .cur    (lex_ff),
      .ch     (req_tdata),
      .at_end (req_tuser),
      .nxt    (lex_in),
      .result (step_res)
   );

   // The all-zero state is the idle mode with an empty run.
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff <= '0;
      end else if (accept) begin
         lex_ff <= lex_in;
      end
   end

   clt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (accept),
      .push       (step_res),
      .pop_ready  (rsp_tready),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room_two   (room_two)
   );

   assign rsp_tdata = {4'd0, head.truncated, head.kw_index, head.symbol, head.length};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

`ifndef SYNTHESIS
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      lex_ff.run_length <= 8'(LEN_CAP))
      else $error("run length above its cap");

   a_ovf_at_cap: assert property (@(posedge clock) disable iff (reset)
      lex_ff.overflowed |-> lex_ff.run_length == 8'(LEN_CAP))
      else $error("overflow flagged below the cap");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> lex_ff.mode == clt_pkg::MODE_IDLE)
      else $error("lexer not idle after end of input");
`endif

endmodule

// ----- hdl/clt_step.sv -----
// Combinational lexer step: next mode and up to two token reports per byte.
module clt_step #(
   parameter int LEN_CAP = 255
) (
   input  clt_pkg::lex_state_type cur,
   input  logic [7:0]             ch,
   input  logic                   at_end,
   output clt_pkg::lex_state_type nxt,
   output clt_pkg::step_out_type  result
);

   logic do_start;
   logic comment_end;
   logic emit_flush;
   logic flush_ok;
   logic second_ok;
   clt_pkg::token_type flush_tok;
   clt_pkg::token_type second_tok;
   clt_pkg::kw_hit_type hit;
   clt_pkg::lex_state_type start_st;

   function automatic clt_pkg::lex_state_type append(input clt_pkg::lex_state_type s,
                                                     input logic [7:0] c);
      clt_pkg::lex_state_type r;
      r = s;
      if (s.run_length < 8'(LEN_CAP)) begin
         for (int i = 0; i < clt_pkg::PREFIX_BYTES; i++) begin
            if (s.run_length == 8'(i)) begin
               r.prefix[8*i +: 8] = c;
            end
         end
         r.run_length = s.run_length + 8'd1;
      end else begin
         r.overflowed = 1'b1;
      end
      return r;
   endfunction

   // Decide whether the byte closes the pending token and is lexed afresh.
   always_comb begin
      do_start = 1'b0;
      comment_end = 1'b0;
      if (!at_end) begin
         unique case (cur.mode)
            clt_pkg::MODE_SLASH:   do_start = (ch != clt_pkg::CH_SLASH);
            clt_pkg::MODE_COMMENT: comment_end = (ch == clt_pkg::CH_NEWLINE);
            clt_pkg::MODE_WORD: begin
               do_start = !(clt_pkg::is_letter(ch) || clt_pkg::is_digit(ch) ||
                            ch == clt_pkg::CH_UNDERSCORE);
            end
            clt_pkg::MODE_NUMBER:  do_start = !clt_pkg::is_digit(ch);
            default:               do_start = 1'b1;
         endcase
      end
   end

   always_comb begin
      start_st = '0;
      start_st.mode = clt_pkg::MODE_IDLE;
      if (ch == clt_pkg::CH_SLASH) begin
         start_st.mode = clt_pkg::MODE_SLASH;
      end else if (clt_pkg::is_letter(ch) || ch == clt_pkg::CH_UNDERSCORE) begin
         start_st.mode = clt_pkg::MODE_WORD;
         start_st.run_length = 8'd1;
         start_st.prefix = {40'd0, ch};
      end else if (clt_pkg::is_digit(ch)) begin
         start_st.mode = clt_pkg::MODE_NUMBER;
         start_st.run_length = 8'd1;
         start_st.prefix = {40'd0, ch};
      end
   end

   // Next state.
   always_comb begin
      nxt = cur;
      if (at_end || comment_end) begin
         nxt = '0;
         nxt.mode = clt_pkg::MODE_IDLE;
      end else if (do_start) begin
         nxt = start_st;
      end else begin
         unique case (cur.mode)
            clt_pkg::MODE_SLASH:  nxt.mode = clt_pkg::MODE_COMMENT;
            clt_pkg::MODE_WORD,
            clt_pkg::MODE_NUMBER: nxt = append(cur, ch);
            default:              nxt = cur;
         endcase
      end
   end

   assign hit = clt_pkg::kw_lookup(cur.prefix, cur.run_length);

   // Token reports.
   always_comb begin
      flush_tok = '0;
      flush_ok = 1'b1;
      unique case (cur.mode)
         clt_pkg::MODE_SLASH: begin
            flush_tok.kind = clt_pkg::KIND_OPER;
            flush_tok.length = 8'd1;
            flush_tok.symbol = clt_pkg::CH_SLASH;
         end
         clt_pkg::MODE_COMMENT: flush_tok.kind = clt_pkg::KIND_COMMENT;
         clt_pkg::MODE_WORD: begin
            flush_tok.length = cur.run_length;
            if (!cur.overflowed && hit.found) begin
               flush_tok.kind = clt_pkg::KIND_KEYWORD;
               flush_tok.kw_index = hit.index;
            end else begin
               flush_tok.kind = clt_pkg::KIND_IDENT;
               flush_tok.truncated = cur.overflowed;
            end
         end
         clt_pkg::MODE_NUMBER: begin
            flush_tok.kind = clt_pkg::KIND_NUMBER;
            flush_tok.length = cur.run_length;
            flush_tok.truncated = cur.overflowed;
         end
         default: flush_ok = 1'b0;
      endcase

      second_tok = '0;
      second_tok.last = 1'b1;
      second_ok = 1'b0;
      if (at_end) begin
         second_ok = 1'b1;
         second_tok.kind = clt_pkg::KIND_END;
      end else if (do_start && !clt_pkg::is_space(ch) && start_st.mode == clt_pkg::MODE_IDLE) begin
         second_ok = 1'b1;
         second_tok.length = 8'd1;
         second_tok.symbol = ch;
         if (clt_pkg::is_oper(ch)) begin
            second_tok.kind = clt_pkg::KIND_OPER;
         end else if (clt_pkg::is_punct(ch)) begin
            second_tok.kind = clt_pkg::KIND_PUNCT;
         end else begin
            second_tok.kind = clt_pkg::KIND_ERROR;
         end
      end

      emit_flush = flush_ok && (at_end || do_start || comment_end);
      result.count = 2'({1'b0, emit_flush}) + 2'({1'b0, second_ok});
      result.first = emit_flush ? flush_tok : second_tok;
      result.first.last = !(emit_flush && second_ok);
      result.second = second_tok;
   end

endmodule

// ----- hdl/clt_fifo.sv -----
// Four-entry result queue that takes up to two tokens per cycle.
module clt_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  clt_pkg::step_out_type push,
   input  logic                  pop_ready,
   output clt_pkg::token_type    head,
   output logic                  head_valid,
   output logic                  room_two
);

   localparam int PTR_W = $clog2(clt_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(clt_pkg::QUEUE_DEPTH + 1);

   clt_pkg::token_type mem_ff [clt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0] push_n;
   logic pop;

   assign push_n = push_en ? push.count : 2'd0;
   assign pop = head_valid && pop_ready;
   assign head_valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];
   assign room_two = (count_ff <= CNT_W'(clt_pkg::QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(clt_pkg::QUEUE_DEPTH))
      else $error("result queue count exceeds its depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> count_ff <= CNT_W'(clt_pkg::QUEUE_DEPTH - 2))
      else $error("tokens pushed without room for two");
`endif

endmodule
